@@ rtl/sdi12crc_pkg.sv @@
// ----------------------------------------------------------------------------
// sdi12crc_pkg
// Shared constants, the sequencer state type and the byte-wide CRC-16 update
// for the SDI-12 response CRC block.
// ----------------------------------------------------------------------------
package sdi12crc_pkg;

  // crc-16, reflected polynomial, start value zero
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  // hold-back depth per mode
  localparam int          HOLD_DEPTH  = 5;
  localparam logic [2:0]  DEPTH_CHECK = 3'd5;
  localparam logic [2:0]  DEPTH_APPND = 3'd2;
  localparam logic [2:0]  CRC_CHARS   = 3'd3;

  // mode register codes
  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_CHECK  = 1'b1;

  // characters
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] ASCII_OFS = 8'h40;
  localparam logic [7:0] RX_MASK   = 8'hBF;

  // flush sequencer, one-hot
  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DATA = 8'b0000_0010,
    ST_CRC1 = 8'b0000_0100,
    ST_CRC2 = 8'b0000_1000,
    ST_CRC3 = 8'b0001_0000,
    ST_CR   = 8'b0010_0000,
    ST_LF   = 8'b0100_0000,
    ST_CHK  = 8'b1000_0000
  } state_t;

  // one character through the crc, lsb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/sdi12_ascii_crc_append_check.sv @@
// ----------------------------------------------------------------------------
// sdi12_ascii_crc_append_check
// SDI-12 response CRC: appends the three-character ASCII CRC and CR LF, or
// checks the received CRC and reports a mismatch flag.
// ----------------------------------------------------------------------------
// Characters of one response enter on the slave stream, one word per cycle
// while the sequencer is idle and the output slot is free, the final one
// marked by s_tlast. The newest characters are held back (two in append mode,
// five in check mode) so that a trailing CR LF and the received CRC can be
// told apart from data; a character leaving the hold is run through the
// byte-wide CRC unit in the cycle it is accepted, so words other than the last
// are taken back to back while the output is not stalled. After the last word
// the flush sequencer empties the hold through the same CRC unit, one
// character per cycle while the output slot is free, then in append mode sends
// the three CRC characters, CR and LF, and in check mode sends one word with
// the mismatch flag. No new word is taken during the flush; a new word is taken
// in the cycle that a waiting result leaves the output register. Writing the
// mode register drops any response in progress and clears the CRC.
// ----------------------------------------------------------------------------
module sdi12_ascii_crc_append_check (
  input  logic       clk,
  input  logic       rst,
  // mode register write
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  // input characters
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // last_byte
  // results
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // [0] crc_mismatch
  output logic       m_tlast    // run_last
);

  // registers
  logic                   mode;
  sdi12crc_pkg::state_t   state, state_next;
  logic [15:0]            crc, crc_next;
  logic [7:0]             hold [sdi12crc_pkg::HOLD_DEPTH];
  logic [7:0]             hold_next [sdi12crc_pkg::HOLD_DEPTH];
  logic [7:0]             tail [4];
  logic [2:0]             held_count, held_count_next;
  logic [2:0]             flush_count, flush_count_next;
  logic [15:0]            rx_crc, rx_crc_next;
  logic                   out_valid, out_valid_next;
  logic [7:0]             out_byte, out_byte_next;
  logic                   out_mis, out_mis_next;
  logic                   out_last, out_last_next;

  // decode signals
  logic        slot_free, in_fire, out_load;
  logic [2:0]  depth, n_after, pos, cnt, data_cnt;
  logic        full, crlf, has_rx;
  logic [7:0]  c0, c1, c2;
  logic [19:0] rx_wide;

  assign slot_free = !out_valid || m_tready;
  assign s_tready  = (state == sdi12crc_pkg::ST_IDLE) && slot_free;
  assign in_fire   = s_tvalid && s_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tuser  = out_mis;
  assign m_tlast  = out_last;

  // hold bookkeeping for an accepted word
  always_comb begin
    depth   = (mode == sdi12crc_pkg::MODE_CHECK) ? sdi12crc_pkg::DEPTH_CHECK
                                                 : sdi12crc_pkg::DEPTH_APPND;
    full    = (held_count == depth);
    n_after = full ? depth : held_count + 3'd1;
    pos     = full ? depth - 3'd1 : held_count;
    crlf    = (n_after >= 3'd2) && (tail[0] == sdi12crc_pkg::CHAR_CR) &&
              (s_tdata == sdi12crc_pkg::CHAR_LF);
    cnt     = crlf ? n_after - 3'd2 : n_after;
    has_rx  = (mode == sdi12crc_pkg::MODE_CHECK) && (cnt >= sdi12crc_pkg::CRC_CHARS);
    data_cnt = has_rx ? cnt - sdi12crc_pkg::CRC_CHARS : cnt;
    // received crc characters, oldest first
    if (crlf) begin
      c0 = tail[3];
      c1 = tail[2];
      c2 = tail[1];
    end else begin
      c0 = tail[1];
      c1 = tail[0];
      c2 = s_tdata;
    end
    rx_wide = ({12'h000, c0 & sdi12crc_pkg::RX_MASK} << 12) |
              ({12'h000, c1 & sdi12crc_pkg::RX_MASK} << 6) |
              {12'h000, c2 & sdi12crc_pkg::RX_MASK};
  end

  // sequencer and datapath
  always_comb begin
    state_next       = state;
    crc_next         = crc;
    held_count_next  = held_count;
    flush_count_next = flush_count;
    rx_crc_next      = rx_crc;
    out_load         = 1'b0;
    out_byte_next    = out_byte;
    out_mis_next     = out_mis;
    out_last_next    = out_last;
    for (int i = 0; i < sdi12crc_pkg::HOLD_DEPTH; i++) begin
      hold_next[i] = hold[i];
    end

    unique case (state)
      sdi12crc_pkg::ST_IDLE: begin
        if (in_fire) begin
          // oldest character leaves a full hold
          if (full) begin
            crc_next = sdi12crc_pkg::crc16_byte(crc, hold[0]);
            if (mode == sdi12crc_pkg::MODE_APPEND) begin
              out_load      = 1'b1;
              out_byte_next = hold[0];
              out_mis_next  = 1'b0;
              out_last_next = 1'b0;
            end
            for (int i = 0; i < sdi12crc_pkg::HOLD_DEPTH - 1; i++) begin
              hold_next[i] = hold[i + 1];
            end
          end
          for (int i = 0; i < sdi12crc_pkg::HOLD_DEPTH; i++) begin
            if (3'(i) == pos) begin
              hold_next[i] = s_tdata;
            end
          end
          if (!s_tlast) begin
            held_count_next = n_after;
          end else begin
            held_count_next  = 3'd0;
            flush_count_next = data_cnt;
            rx_crc_next      = has_rx ? rx_wide[15:0] : 16'h0000;
            if (data_cnt != 3'd0) begin
              state_next = sdi12crc_pkg::ST_DATA;
            end else if (mode == sdi12crc_pkg::MODE_CHECK) begin
              state_next = sdi12crc_pkg::ST_CHK;
            end else begin
              state_next = sdi12crc_pkg::ST_CRC1;
            end
          end
        end
      end
      sdi12crc_pkg::ST_DATA: begin
        // drain held data, one character a cycle while the output slot is free
        if (slot_free) begin
          crc_next = sdi12crc_pkg::crc16_byte(crc, hold[0]);
          if (mode == sdi12crc_pkg::MODE_APPEND) begin
            out_load      = 1'b1;
            out_byte_next = hold[0];
            out_mis_next  = 1'b0;
            out_last_next = 1'b0;
          end
          for (int i = 0; i < sdi12crc_pkg::HOLD_DEPTH - 1; i++) begin
            hold_next[i] = hold[i + 1];
          end
          flush_count_next = flush_count - 3'd1;
          if (flush_count == 3'd1) begin
            state_next = (mode == sdi12crc_pkg::MODE_CHECK) ? sdi12crc_pkg::ST_CHK
                                                            : sdi12crc_pkg::ST_CRC1;
          end
        end
      end
      sdi12crc_pkg::ST_CRC1: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_byte_next = sdi12crc_pkg::ASCII_OFS | {4'h0, crc[15:12]};
          out_mis_next  = 1'b0;
          out_last_next = 1'b0;
          state_next    = sdi12crc_pkg::ST_CRC2;
        end
      end
      sdi12crc_pkg::ST_CRC2: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_byte_next = sdi12crc_pkg::ASCII_OFS | {2'b00, crc[11:6]};
          out_mis_next  = 1'b0;
          out_last_next = 1'b0;
          state_next    = sdi12crc_pkg::ST_CRC3;
        end
      end
      sdi12crc_pkg::ST_CRC3: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_byte_next = sdi12crc_pkg::ASCII_OFS | {2'b00, crc[5:0]};
          out_mis_next  = 1'b0;
          out_last_next = 1'b0;
          state_next    = sdi12crc_pkg::ST_CR;
        end
      end
      sdi12crc_pkg::ST_CR: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_byte_next = sdi12crc_pkg::CHAR_CR;
          out_mis_next  = 1'b0;
          out_last_next = 1'b0;
          state_next    = sdi12crc_pkg::ST_LF;
        end
      end
      sdi12crc_pkg::ST_LF: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_byte_next = sdi12crc_pkg::CHAR_LF;
          out_mis_next  = 1'b0;
          out_last_next = 1'b1;
          crc_next      = sdi12crc_pkg::CRC_INIT;
          state_next    = sdi12crc_pkg::ST_IDLE;
        end
      end
      sdi12crc_pkg::ST_CHK: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_byte_next = 8'h00;
          out_mis_next  = (rx_crc != crc);
          out_last_next = 1'b1;
          crc_next      = sdi12crc_pkg::CRC_INIT;
          state_next    = sdi12crc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sdi12crc_pkg::ST_IDLE;
      end
    endcase

    out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= sdi12crc_pkg::MODE_APPEND;
      state      <= sdi12crc_pkg::ST_IDLE;
      crc        <= sdi12crc_pkg::CRC_INIT;
      held_count <= 3'd0;
      out_valid  <= 1'b0;
    end else if (cfg_we) begin
      mode       <= cfg_wdata;
      state      <= sdi12crc_pkg::ST_IDLE;
      crc        <= sdi12crc_pkg::CRC_INIT;
      held_count <= 3'd0;
      out_valid  <= out_valid_next;
    end else begin
      state      <= state_next;
      crc        <= crc_next;
      held_count <= held_count_next;
      out_valid  <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < sdi12crc_pkg::HOLD_DEPTH; i++) begin
      hold[i] <= hold_next[i];
    end
    // newest-first line of accepted characters
    if (in_fire) begin
      tail[0] <= s_tdata;
      for (int i = 1; i < 4; i++) begin
        tail[i] <= tail[i - 1];
      end
    end
    flush_count <= flush_count_next;
    rx_crc      <= rx_crc_next;
    out_byte    <= out_byte_next;
    out_mis     <= out_mis_next;
    out_last    <= out_last_next;
  end

endmodule
